FILE: hw/rtl/rah_pkg.sv
// Shared constants, types and the bin search function of the region angle histogram.
`default_nettype none
package rah_pkg;

    localparam int MAX_REGIONS = 256;
    localparam int MAX_BINS    = 8;
    localparam int COUNT_WIDTH = 24;
    localparam int ANGLE_WIDTH = 16;

    localparam int EDGE_SLOT   = 16;
    localparam int EDGE_WORD_W = 4 * EDGE_SLOT;
    localparam int REGION_W    = 9;
    localparam int BIN_W       = $clog2(MAX_BINS);
    localparam int ROW_W       = $clog2(MAX_REGIONS);
    localparam int ADDR_W      = ROW_W + BIN_W;
    localparam int DEPTH       = MAX_REGIONS * MAX_BINS;
    localparam int USED_W      = 4;
    localparam int STATUS_W    = 3;

    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;
    localparam int REG_IDX_W   = 3;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_INC_EDGES_FIRST  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INC_EDGES_SECOND = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AZ_EDGES_FIRST   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_AZ_EDGES_SECOND  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INC_BINS_USED    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_AZ_BINS_USED     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_NUM_REGIONS      = 3'd6;

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNLABELED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BELOW     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [REGION_W-1:0]    REGION_CAP = REGION_W'(MAX_REGIONS);

    typedef struct packed {
        logic [EDGE_WORD_W-1:0] inc_edges_first;
        logic [EDGE_WORD_W-1:0] inc_edges_second;
        logic [EDGE_WORD_W-1:0] az_edges_first;
        logic [EDGE_WORD_W-1:0] az_edges_second;
        logic [USED_W-1:0]      inc_bins_used;
        logic [USED_W-1:0]      az_bins_used;
        logic [REGION_W-1:0]    num_regions;
    } cfg_t;

    typedef struct packed {
        logic             hit;
        logic [BIN_W-1:0] bin;
    } bin_hit_t;

    // Highest edge in use that the value is at or above; hit is low when there is none.
    function automatic bin_hit_t find_bin(
        input logic signed [ANGLE_WIDTH-1:0] value,
        input logic [EDGE_WORD_W-1:0]        lo,
        input logic [EDGE_WORD_W-1:0]        hi,
        input logic [USED_W-1:0]             used
    );
        logic [2*EDGE_WORD_W-1:0] edges;
        logic signed [EDGE_SLOT-1:0] edge_val;
        bin_hit_t res;
        edges = {hi, lo};
        res = '0;
        for (int k = 0; k < MAX_BINS; k++) begin
            edge_val = $signed(edges[EDGE_SLOT*k +: EDGE_SLOT]);
            if ((USED_W'(k) < used) && (value >= edge_val)) begin
                res.hit = 1'b1;
                res.bin = BIN_W'(k);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rah_in_if.sv
// Input channel of the region angle histogram: one pixel or read request per transfer.
`default_nettype none
interface rah_in_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     opcode;
    logic [rah_pkg::REGION_W-1:0]             region;
    logic signed [rah_pkg::ANGLE_WIDTH-1:0]   inclination;
    logic signed [rah_pkg::ANGLE_WIDTH-1:0]   azimuth;
    logic [rah_pkg::BIN_W-1:0]                read_bin;

    modport source (output valid, opcode, region, inclination, azimuth, read_bin,
                    input ready);
    modport sink (input valid, opcode, region, inclination, azimuth, read_bin,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rah_out_if.sv
// Result channel of the region angle histogram: counts, bins and status per transfer.
`default_nettype none
interface rah_out_if;
    logic                               valid;
    logic                               ready;
    logic [rah_pkg::COUNT_WIDTH-1:0]    inc_count;
    logic [rah_pkg::COUNT_WIDTH-1:0]    az_count;
    logic [rah_pkg::BIN_W-1:0]          inc_bin_found;
    logic [rah_pkg::BIN_W-1:0]          az_bin_found;
    logic [rah_pkg::STATUS_W-1:0]       status;

    modport source (output valid, inc_count, az_count, inc_bin_found, az_bin_found, status,
                    input ready);
    modport sink (input valid, inc_count, az_count, inc_bin_found, az_bin_found, status,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rah_cfg.sv
// APB-style configuration registers of the region angle histogram.
`default_nettype none
module rah_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rah_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [rah_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [rah_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output rah_pkg::cfg_t                          cfg
);

    rah_pkg::cfg_t cfg_reg;
    rah_pkg::cfg_t cfg_next;
    logic [rah_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[rah_pkg::APB_ADDR_W-1:rah_pkg::APB_ADDR_W-rah_pkg::REG_IDX_W];
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                rah_pkg::REG_INC_EDGES_FIRST:  cfg_next.inc_edges_first  = pwdata;
                rah_pkg::REG_INC_EDGES_SECOND: cfg_next.inc_edges_second = pwdata;
                rah_pkg::REG_AZ_EDGES_FIRST:   cfg_next.az_edges_first   = pwdata;
                rah_pkg::REG_AZ_EDGES_SECOND:  cfg_next.az_edges_second  = pwdata;
                rah_pkg::REG_INC_BINS_USED:
                    cfg_next.inc_bins_used = pwdata[rah_pkg::USED_W-1:0];
                rah_pkg::REG_AZ_BINS_USED:
                    cfg_next.az_bins_used = pwdata[rah_pkg::USED_W-1:0];
                rah_pkg::REG_NUM_REGIONS:
                    cfg_next.num_regions = pwdata[rah_pkg::REGION_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            rah_pkg::REG_INC_EDGES_FIRST:  prdata = cfg_reg.inc_edges_first;
            rah_pkg::REG_INC_EDGES_SECOND: prdata = cfg_reg.inc_edges_second;
            rah_pkg::REG_AZ_EDGES_FIRST:   prdata = cfg_reg.az_edges_first;
            rah_pkg::REG_AZ_EDGES_SECOND:  prdata = cfg_reg.az_edges_second;
            rah_pkg::REG_INC_BINS_USED:
                prdata = rah_pkg::APB_DATA_W'(cfg_reg.inc_bins_used);
            rah_pkg::REG_AZ_BINS_USED:
                prdata = rah_pkg::APB_DATA_W'(cfg_reg.az_bins_used);
            rah_pkg::REG_NUM_REGIONS:
                prdata = rah_pkg::APB_DATA_W'(cfg_reg.num_regions);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inc_edges_first  <= '0;
            cfg_reg.inc_edges_second <= '0;
            cfg_reg.az_edges_first   <= '0;
            cfg_reg.az_edges_second  <= '0;
            cfg_reg.inc_bins_used    <= rah_pkg::USED_W'(rah_pkg::MAX_BINS);
            cfg_reg.az_bins_used     <= rah_pkg::USED_W'(rah_pkg::MAX_BINS);
            cfg_reg.num_regions      <= rah_pkg::REGION_CAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rah_count_ram.sv
// Histogram count memory: one write port and one read port with registered read data.
`default_nettype none
module rah_count_ram (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [rah_pkg::ADDR_W-1:0]         waddr,
    input  wire logic [rah_pkg::COUNT_WIDTH-1:0]    wdata,
    input  wire logic                               re,
    input  wire logic [rah_pkg::ADDR_W-1:0]         raddr,
    output logic      [rah_pkg::COUNT_WIDTH-1:0]    rdata
);

    logic [rah_pkg::COUNT_WIDTH-1:0] store_mem [rah_pkg::DEPTH];
    logic [rah_pkg::COUNT_WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    // A read of the entry being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/region_angle_histogram.sv
// Top level of the region angle histogram: bin search, count update pipeline and clearing.
//
//   channel   direction  handshake          carries
//   in_ch     in         valid/ready        opcode, region, inclination, azimuth, read_bin
//   out_ch    out        valid/ready        inc_count, az_count, bins found, status
//   APB       in/out     psel/penable       configuration registers at 8*index
//
// An item goes from transfer to result in steps: the bin search and memory read, then the
// count update and write-back, then the output register. One item can enter every cycle
// unless clearing runs or a stalled result holds the update stage; an update to the entry
// written in the same cycle is forwarded past the memory. After reset both count memories
// are cleared one entry a cycle, all 2048 entries, before the first input transfer is taken.
// A stalled result holds the update stage, which in turn holds the input.
`default_nettype none
module region_angle_histogram (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rah_in_if.sink                                 in_ch,
    rah_out_if.source                              out_ch,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rah_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [rah_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [rah_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    localparam logic [1:0] KIND_SKIP  = 2'd0;
    localparam logic [1:0] KIND_RANGE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_ACC   = 2'd3;

    localparam int CW = rah_pkg::COUNT_WIDTH;
    localparam int AW = rah_pkg::ADDR_W;
    localparam int BW = rah_pkg::BIN_W;

    rah_pkg::cfg_t cfg;

    // Clearing sequencer.
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Accept stage.
    logic                         accept;
    logic [rah_pkg::REGION_W-1:0] limit;
    rah_pkg::bin_hit_t            inc_hit, az_hit;
    logic                         is_read;
    logic [BW-1:0]                inc_sel_bin, az_sel_bin;
    logic [rah_pkg::ROW_W-1:0]    row;
    logic [AW-1:0]                a_inc_addr, a_az_addr;
    logic [1:0]                   a_kind;

    // Update stage.
    logic          s1_valid_reg, s1_valid_next;
    logic [1:0]    s1_kind_reg;
    logic [AW-1:0] s1_inc_addr_reg, s1_az_addr_reg;
    logic          s1_inc_hit_reg, s1_az_hit_reg;
    logic [BW-1:0] s1_inc_bin_reg, s1_az_bin_reg;
    logic          s1_inc_fwd_reg, s1_az_fwd_reg;
    logic [CW-1:0] s1_inc_fwd_data_reg, s1_az_fwd_data_reg;
    logic          s1_adv;

    logic [CW-1:0] inc_rdata, az_rdata;
    logic [CW-1:0] inc_old, az_old, inc_new, az_new;
    logic          inc_sat, az_sat;
    logic          inc_upd, az_upd;
    logic          inc_we, az_we;
    logic [AW-1:0] inc_waddr, az_waddr;
    logic [CW-1:0] inc_wdata, az_wdata;

    logic [CW-1:0]                r_inc_count, r_az_count;
    logic [BW-1:0]                r_inc_bin, r_az_bin;
    logic [rah_pkg::STATUS_W-1:0] r_status;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic [CW-1:0]                out_inc_count_reg, out_az_count_reg;
    logic [BW-1:0]                out_inc_bin_reg, out_az_bin_reg;
    logic [rah_pkg::STATUS_W-1:0] out_status_reg;

    rah_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == {AW{1'b1}})
            begin
                clearing_next = 1'b0;
            end
        end
    end

    assign s1_adv       = s1_valid_reg & (~out_valid_reg | out_ch.ready);
    assign in_ch.ready  = ~clearing_reg & (~s1_valid_reg | s1_adv);
    assign accept       = in_ch.valid & in_ch.ready;

    assign limit   = (cfg.num_regions < rah_pkg::REGION_CAP) ? cfg.num_regions
                                                            : rah_pkg::REGION_CAP;
    assign inc_hit = rah_pkg::find_bin(in_ch.inclination, cfg.inc_edges_first,
                                       cfg.inc_edges_second, cfg.inc_bins_used);
    assign az_hit  = rah_pkg::find_bin(in_ch.azimuth, cfg.az_edges_first,
                                       cfg.az_edges_second, cfg.az_bins_used);
    assign is_read = (in_ch.opcode == rah_pkg::OP_READ);

    assign inc_sel_bin = is_read ? in_ch.read_bin : inc_hit.bin;
    assign az_sel_bin  = is_read ? in_ch.read_bin : az_hit.bin;
    assign row         = rah_pkg::ROW_W'(in_ch.region - rah_pkg::REGION_W'(1));
    assign a_inc_addr  = {row, inc_sel_bin};
    assign a_az_addr   = {row, az_sel_bin};

    always_comb
    begin
        if (in_ch.region == '0)
        begin
            a_kind = KIND_SKIP;
        end
        else if (in_ch.region > limit)
        begin
            a_kind = KIND_RANGE;
        end
        else if (is_read)
        begin
            a_kind = KIND_READ;
        end
        else
        begin
            a_kind = KIND_ACC;
        end
    end

    // Update stage: the stored count, or the value written to the same entry as this
    // item was read.
    assign inc_old = s1_inc_fwd_reg ? s1_inc_fwd_data_reg : inc_rdata;
    assign az_old  = s1_az_fwd_reg ? s1_az_fwd_data_reg : az_rdata;
    assign inc_sat = (inc_old == rah_pkg::COUNT_MAX);
    assign az_sat  = (az_old == rah_pkg::COUNT_MAX);
    assign inc_new = inc_sat ? inc_old : inc_old + CW'(1);
    assign az_new  = az_sat ? az_old : az_old + CW'(1);
    assign inc_upd = s1_adv & (s1_kind_reg == KIND_ACC) & s1_inc_hit_reg;
    assign az_upd  = s1_adv & (s1_kind_reg == KIND_ACC) & s1_az_hit_reg;

    assign inc_we    = clearing_reg | inc_upd;
    assign az_we     = clearing_reg | az_upd;
    assign inc_waddr = clearing_reg ? clr_cnt_reg : s1_inc_addr_reg;
    assign az_waddr  = clearing_reg ? clr_cnt_reg : s1_az_addr_reg;
    assign inc_wdata = clearing_reg ? '0 : inc_new;
    assign az_wdata  = clearing_reg ? '0 : az_new;

    rah_count_ram u_inc_ram (
        .clk   (clk),
        .we    (inc_we),
        .waddr (inc_waddr),
        .wdata (inc_wdata),
        .re    (accept),
        .raddr (a_inc_addr),
        .rdata (inc_rdata)
    );

    rah_count_ram u_az_ram (
        .clk   (clk),
        .we    (az_we),
        .waddr (az_waddr),
        .wdata (az_wdata),
        .re    (accept),
        .raddr (a_az_addr),
        .rdata (az_rdata)
    );

    always_comb
    begin
        r_inc_count = '0;
        r_az_count  = '0;
        r_inc_bin   = '0;
        r_az_bin    = '0;
        r_status    = rah_pkg::ST_OK;
        unique case (s1_kind_reg)
            KIND_SKIP:  r_status = rah_pkg::ST_UNLABELED;
            KIND_RANGE: r_status = rah_pkg::ST_RANGE;
            KIND_READ:
            begin
                r_inc_count = inc_old;
                r_az_count  = az_old;
                r_inc_bin   = s1_inc_bin_reg;
                r_az_bin    = s1_az_bin_reg;
            end
            KIND_ACC:
            begin
                if (s1_inc_hit_reg)
                begin
                    r_inc_count = inc_new;
                    r_inc_bin   = s1_inc_bin_reg;
                end
                if (s1_az_hit_reg)
                begin
                    r_az_count = az_new;
                    r_az_bin   = s1_az_bin_reg;
                end
                if (!s1_inc_hit_reg || !s1_az_hit_reg)
                begin
                    r_status = rah_pkg::ST_BELOW;
                end
                else if (inc_sat || az_sat)
                begin
                    r_status = rah_pkg::ST_SATURATED;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg         <= a_kind;
            s1_inc_addr_reg     <= a_inc_addr;
            s1_az_addr_reg      <= a_az_addr;
            s1_inc_hit_reg      <= inc_hit.hit;
            s1_az_hit_reg       <= az_hit.hit;
            s1_inc_bin_reg      <= inc_sel_bin;
            s1_az_bin_reg       <= az_sel_bin;
            s1_inc_fwd_reg      <= inc_upd & (s1_inc_addr_reg == a_inc_addr);
            s1_az_fwd_reg       <= az_upd & (s1_az_addr_reg == a_az_addr);
            s1_inc_fwd_data_reg <= inc_new;
            s1_az_fwd_data_reg  <= az_new;
        end
        if (s1_adv)
        begin
            out_inc_count_reg <= r_inc_count;
            out_az_count_reg  <= r_az_count;
            out_inc_bin_reg   <= r_inc_bin;
            out_az_bin_reg    <= r_az_bin;
            out_status_reg    <= r_status;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.inc_count     = out_inc_count_reg;
    assign out_ch.az_count      = out_az_count_reg;
    assign out_ch.inc_bin_found = out_inc_bin_reg;
    assign out_ch.az_bin_found  = out_az_bin_reg;
    assign out_ch.status        = out_status_reg;

endmodule
`default_nettype wire

FILE: tb/tb_region_angle_histogram.sv
// Self-checking testbench of the region angle histogram with a count predictor and scoreboard.
module tb_region_angle_histogram;
    timeunit 1ns;
    timeprecision 1ps;

    import rah_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic                          opcode;
        logic [REGION_W-1:0]           region;
        logic signed [ANGLE_WIDTH-1:0] inclination;
        logic signed [ANGLE_WIDTH-1:0] azimuth;
        logic [BIN_W-1:0]              read_bin;
    } pixel_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] inc_count;
        logic [COUNT_WIDTH-1:0] az_count;
        logic [BIN_W-1:0]       inc_bin_found;
        logic [BIN_W-1:0]       az_bin_found;
        logic [STATUS_W-1:0]    status;
    } tally_t;

    class histogram_scoreboard;
        logic [COUNT_WIDTH-1:0]   inc_counts [DEPTH];
        logic [COUNT_WIDTH-1:0]   az_counts [DEPTH];
        logic [2*EDGE_WORD_W-1:0] inc_edges;
        logic [2*EDGE_WORD_W-1:0] az_edges;
        logic [USED_W-1:0]        inc_used;
        logic [USED_W-1:0]        az_used;
        logic [REGION_W-1:0]      region_limit;
        tally_t                   expected_q[$];
        int                       errors;

        function new();
            foreach (inc_counts[i]) inc_counts[i] = '0;
            foreach (az_counts[i]) az_counts[i] = '0;
            inc_edges = '0;
            az_edges = '0;
            inc_used = USED_W'(8);
            az_used = USED_W'(8);
            region_limit = REGION_CAP;
            errors = 0;
        endfunction

        function void write_setting(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_INC_EDGES_FIRST:  inc_edges[EDGE_WORD_W-1:0] = value;
                REG_INC_EDGES_SECOND: inc_edges[2*EDGE_WORD_W-1:EDGE_WORD_W] = value;
                REG_AZ_EDGES_FIRST:   az_edges[EDGE_WORD_W-1:0] = value;
                REG_AZ_EDGES_SECOND:  az_edges[2*EDGE_WORD_W-1:EDGE_WORD_W] = value;
                REG_INC_BINS_USED:    inc_used = value[USED_W-1:0];
                REG_AZ_BINS_USED:     az_used = value[USED_W-1:0];
                REG_NUM_REGIONS:      region_limit = value[REGION_W-1:0];
                default: ;
            endcase
        endfunction

        function int counted_regions();
            return (int'(region_limit) > MAX_REGIONS) ? MAX_REGIONS : int'(region_limit);
        endfunction

        // Highest edge in use at or below the value, or -1 when the value is under all of them.
        function int search_bin(logic signed [ANGLE_WIDTH-1:0] value,
                                logic [2*EDGE_WORD_W-1:0] edges, logic [USED_W-1:0] used);
            int n;
            int hit;
            hit = -1;
            n = (int'(used) > MAX_BINS) ? MAX_BINS : int'(used);
            for (int k = 0; k < n; k++)
            begin
                if (value >= $signed(edges[EDGE_SLOT*k +: EDGE_SLOT]))
                    hit = k;
            end
            return hit;
        endfunction

        function void note_pixel(pixel_t p);
            tally_t t;
            int     idx;
            int     bi;
            int     ba;
            logic   sat;
            logic   below;
            t = '0;
            sat = 1'b0;
            below = 1'b0;
            if (p.region == '0)
                t.status = ST_UNLABELED;
            else if (int'(p.region) > counted_regions())
                t.status = ST_RANGE;
            else if (p.opcode == OP_READ)
            begin
                idx = (int'(p.region) - 1) * MAX_BINS + int'(p.read_bin);
                t.inc_bin_found = p.read_bin;
                t.az_bin_found = p.read_bin;
                t.inc_count = inc_counts[idx];
                t.az_count = az_counts[idx];
                t.status = ST_OK;
            end
            else
            begin
                bi = search_bin(p.inclination, inc_edges, inc_used);
                ba = search_bin(p.azimuth, az_edges, az_used);
                if (bi >= 0)
                begin
                    idx = (int'(p.region) - 1) * MAX_BINS + bi;
                    if (inc_counts[idx] == COUNT_MAX)
                        sat = 1'b1;
                    else
                        inc_counts[idx] = inc_counts[idx] + 1'b1;
                    t.inc_count = inc_counts[idx];
                    t.inc_bin_found = BIN_W'(bi);
                end
                else
                    below = 1'b1;
                if (ba >= 0)
                begin
                    idx = (int'(p.region) - 1) * MAX_BINS + ba;
                    if (az_counts[idx] == COUNT_MAX)
                        sat = 1'b1;
                    else
                        az_counts[idx] = az_counts[idx] + 1'b1;
                    t.az_count = az_counts[idx];
                    t.az_bin_found = BIN_W'(ba);
                end
                else
                    below = 1'b1;
                t.status = below ? ST_BELOW : (sat ? ST_SATURATED : ST_OK);
            end
            expected_q.push_back(t);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_tally(tally_t got);
            tally_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual %p", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("inc_count", want.inc_count, got.inc_count);
            compare_field("az_count", want.az_count, got.az_count);
            compare_field("inc_bin_found", want.inc_bin_found, got.inc_bin_found);
            compare_field("az_bin_found", want.az_bin_found, got.az_bin_found);
            compare_field("status", want.status, got.status);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    idle_cycles = 0;
    histogram_scoreboard   sb = new();

    rah_in_if  in_ch();
    rah_out_if out_ch();

    region_angle_histogram dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side stalls at random, one decision per cycle.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor and watchdog: values seen here are the ones present at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_pixel({in_ch.opcode, in_ch.region, in_ch.inclination, in_ch.azimuth,
                           in_ch.read_bin});
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_tally({out_ch.inc_count, out_ch.az_count, out_ch.inc_bin_found,
                            out_ch.az_bin_found, out_ch.status});
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_setting(idx, value);
        // psel drops between transfers.
        @(posedge clk);
    endtask

    task automatic load_settings(logic [2*EDGE_WORD_W-1:0] inc_e, logic [2*EDGE_WORD_W-1:0] az_e,
                                 logic [USED_W-1:0] inc_u, logic [USED_W-1:0] az_u,
                                 logic [REGION_W-1:0] regions);
        apb_write(REG_INC_EDGES_FIRST, inc_e[EDGE_WORD_W-1:0]);
        apb_write(REG_INC_EDGES_SECOND, inc_e[2*EDGE_WORD_W-1:EDGE_WORD_W]);
        apb_write(REG_AZ_EDGES_FIRST, az_e[EDGE_WORD_W-1:0]);
        apb_write(REG_AZ_EDGES_SECOND, az_e[2*EDGE_WORD_W-1:EDGE_WORD_W]);
        apb_write(REG_INC_BINS_USED, APB_DATA_W'(inc_u));
        apb_write(REG_AZ_BINS_USED, APB_DATA_W'(az_u));
        apb_write(REG_NUM_REGIONS, APB_DATA_W'(regions));
    endtask

    task automatic send_pixel(pixel_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= p.opcode;
        in_ch.region <= p.region;
        in_ch.inclination <= p.inclination;
        in_ch.azimuth <= p.azimuth;
        in_ch.read_bin <= p.read_bin;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Lower valid, wait for every expected result, then let the pipeline settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic pixel_t make_pixel(logic op, int region, int inc, int az, int rbin);
        pixel_t p;
        p.opcode = op;
        p.region = REGION_W'(region);
        p.inclination = ANGLE_WIDTH'(inc);
        p.azimuth = ANGLE_WIDTH'(az);
        p.read_bin = BIN_W'(rbin);
        return p;
    endfunction

    // Style 0 sorted, style 1 unordered, style 2 sorted and spanning the full angle range.
    function automatic logic [2*EDGE_WORD_W-1:0] pick_edges(int style);
        int                       vals[$];
        logic [2*EDGE_WORD_W-1:0] packed_edges;
        for (int k = 0; k < MAX_BINS; k++)
            vals.push_back(int'($urandom_range(65535)) - 32768);
        if (style != 1)
            vals.sort();
        if (style == 2)
        begin
            vals[0] = -32768;
            vals[MAX_BINS-1] = 32767;
        end
        for (int k = 0; k < MAX_BINS; k++)
            packed_edges[EDGE_SLOT*k +: EDGE_SLOT] = EDGE_SLOT'(vals[k]);
        return packed_edges;
    endfunction

    // Angles cluster on the configured edges so that the compare boundaries get exercised.
    function automatic logic signed [ANGLE_WIDTH-1:0] pick_angle(logic [2*EDGE_WORD_W-1:0] edges);
        int                            k;
        logic signed [ANGLE_WIDTH-1:0] e;
        k = $urandom_range(MAX_BINS-1);
        e = edges[EDGE_SLOT*k +: EDGE_SLOT];
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2, 3, 4, 5: return ANGLE_WIDTH'(int'(e) + int'($urandom_range(2)) - 1);
            default: return ANGLE_WIDTH'($urandom);
        endcase
    endfunction

    // Most pixels land on a few hot regions so that counts build up and reads see them.
    function automatic logic [REGION_W-1:0] pick_region(int limit);
        case ($urandom_range(11))
            0: return '0;
            1: return REGION_W'(limit);
            2: return REGION_W'(limit + 1);
            3: return REGION_W'($urandom);
            default: return REGION_W'($urandom_range((limit < 4) ? limit : 4, 1));
        endcase
    endfunction

    function automatic pixel_t random_pixel(int limit);
        pixel_t p;
        p.opcode = ($urandom_range(3) == 0) ? OP_READ : OP_ACCUMULATE;
        p.region = pick_region(limit);
        p.inclination = pick_angle(sb.inc_edges);
        p.azimuth = pick_angle(sb.az_edges);
        p.read_bin = BIN_W'($urandom_range(MAX_BINS-1));
        return p;
    endfunction

    initial
    begin
        logic [2*EDGE_WORD_W-1:0] inc_e;
        logic [2*EDGE_WORD_W-1:0] az_e;
        logic [USED_W-1:0]        inc_u;
        logic [USED_W-1:0]        az_u;
        logic [REGION_W-1:0]      regions;
        int                       limit;

        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.opcode <= OP_ACCUMULATE;
        in_ch.region <= '0;
        in_ch.inclination <= '0;
        in_ch.azimuth <= '0;
        in_ch.read_bin <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: every edge at zero, so a non-negative angle lands in the top bin.
        send_pixel(make_pixel(OP_ACCUMULATE, 1, 0, 0, 0));
        send_pixel(make_pixel(OP_ACCUMULATE, 1, -1, 5, 0));
        send_pixel(make_pixel(OP_READ, 1, 0, 0, 7));
        drain();

        load_settings(128'h6000_4000_2000_0000_E000_C000_A000_8000,
                      128'h3A98_2710_1388_0000_EC78_D8F0_C568_B1E0,
                      USED_W'(8), USED_W'(5), REGION_W'(200));
        send_pixel(make_pixel(OP_ACCUMULATE, 200, -32768, 32767, 0));
        send_pixel(make_pixel(OP_ACCUMULATE, 201, 0, 0, 0));
        send_pixel(make_pixel(OP_ACCUMULATE, 256, 0, 0, 0));
        send_pixel(make_pixel(OP_ACCUMULATE, 511, 0, 0, 0));
        send_pixel(make_pixel(OP_ACCUMULATE, 0, 100, 100, 0));
        send_pixel(make_pixel(OP_ACCUMULATE, 1, 32767, -32768, 0));
        // Exactly on an edge, one below an edge, and an edge beyond those in use.
        send_pixel(make_pixel(OP_ACCUMULATE, 1, 8192, 4999, 0));
        send_pixel(make_pixel(OP_ACCUMULATE, 1, 8191, 5000, 0));
        send_pixel(make_pixel(OP_ACCUMULATE, 1, -20001, -20001, 0));
        send_pixel(make_pixel(OP_READ, 1, 21845, -21846, 0));
        send_pixel(make_pixel(OP_READ, 1, 0, 0, 7));
        send_pixel(make_pixel(OP_READ, 200, 0, 0, 0));
        send_pixel(make_pixel(OP_READ, 200, 0, 0, 4));
        send_pixel(make_pixel(OP_READ, 0, 0, 0, 5));
        send_pixel(make_pixel(OP_READ, 201, 0, 0, 3));
        drain();

        // A region limit of zero turns every label away.
        apb_write(REG_NUM_REGIONS, '0);
        send_pixel(make_pixel(OP_ACCUMULATE, 1, 0, 0, 0));
        send_pixel(make_pixel(OP_READ, 1, 0, 0, 4));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    inc_e = pick_edges(0);
                    az_e = pick_edges(0);
                    inc_u = USED_W'(8);
                    az_u = USED_W'(8);
                    regions = REGION_W'(256);
                end
                1:
                begin
                    inc_e = pick_edges(0);
                    az_e = pick_edges(2);
                    inc_u = USED_W'(1);
                    az_u = USED_W'(1);
                    regions = REGION_W'(1);
                end
                2:
                begin
                    inc_e = pick_edges(2);
                    az_e = pick_edges(0);
                    inc_u = USED_W'(0);
                    az_u = USED_W'(15);
                    regions = REGION_W'(511);
                end
                3:
                begin
                    inc_e = pick_edges(1);
                    az_e = pick_edges(1);
                    inc_u = USED_W'($urandom_range(8, 1));
                    az_u = USED_W'($urandom_range(8, 1));
                    regions = REGION_W'($urandom_range(256, 1));
                end
                4:
                begin
                    inc_e = pick_edges(2);
                    az_e = pick_edges(2);
                    inc_u = USED_W'(8);
                    az_u = USED_W'(2);
                    regions = REGION_W'(255);
                end
                default:
                begin
                    inc_e = pick_edges($urandom_range(2));
                    az_e = pick_edges($urandom_range(2));
                    inc_u = USED_W'($urandom_range(15));
                    az_u = USED_W'($urandom_range(15));
                    regions = REGION_W'($urandom_range(8, 1));
                end
            endcase
            load_settings(inc_e, az_e, inc_u, az_u, regions);
            case (phase % 3)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 68;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            limit = sb.counted_regions();
            repeat (ITEMS_PER_PHASE) send_pixel(random_pixel(limit));
        end

        drain();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
